[rtl/psvp_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and the arctangent table of the point-source visibility predictor.
// No dependencies.
package psvp_pkg;

    localparam int CORDIC_ITERATIONS_DEFAULT = 16;
    localparam int CORDIC_TABLE_LEN          = 32;

    localparam logic [127:0] INV_C_WIDE =
        (((128'd1 << 72) / 128'd299792458000) + 128'd1) >> 1;
    localparam logic [33:0]  INV_C      = INV_C_WIDE[33:0];

    localparam int CW = 34;
    localparam int PW = 32;
    localparam int MW = 34;

    localparam logic signed [CW-1:0] CORDIC_GAIN  = 34'sd652032874;
    localparam logic [31:0]          QUARTER_HALF = 32'h2000_0000;
    localparam logic [31:0]          FLUX_RESET   = 32'd65536;
    localparam logic [31:0]          SAT_POS      = 32'h7FFF_FFFF;
    localparam logic [31:0]          SAT_NEG      = 32'h8000_0000;

    typedef enum logic [1:0] {
        CFG_SRC_L  = 2'd0,
        CFG_SRC_M  = 2'd1,
        CFG_SRC_N1 = 2'd2,
        CFG_FLUX   = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic signed [MW-1:0] re;
        logic signed [MW-1:0] im;
    } cplx_t;

    typedef cplx_t [3:0] corr4_t;

    typedef struct packed {
        logic signed [31:0] u_m;
        logic signed [31:0] v_m;
        logic signed [31:0] w_m;
        logic [29:0]        freq_hz;
        logic [31:0]        jp_xx;
        logic [31:0]        jp_xy;
        logic [31:0]        jp_yx;
        logic [31:0]        jp_yy;
        logic [31:0]        jq_xx;
        logic [31:0]        jq_xy;
        logic [31:0]        jq_yx;
        logic [31:0]        jq_yy;
    } psvp_in_t;

    typedef struct packed {
        logic [63:0] vis_xx;
        logic [63:0] vis_xy;
        logic [63:0] vis_yx;
        logic [63:0] vis_yy;
    } psvp_out_t;

    function automatic logic [31:0] atan_turn(input int unsigned idx);
        logic [31:0] r;
        case (idx)
            0:  r = 32'd536870912;
            1:  r = 32'd316933406;
            2:  r = 32'd167458907;
            3:  r = 32'd85004756;
            4:  r = 32'd42667331;
            5:  r = 32'd21354465;
            6:  r = 32'd10679838;
            7:  r = 32'd5340245;
            8:  r = 32'd2670163;
            9:  r = 32'd1335087;
            10: r = 32'd667544;
            11: r = 32'd333772;
            12: r = 32'd166886;
            13: r = 32'd83443;
            14: r = 32'd41722;
            15: r = 32'd20861;
            16: r = 32'd10430;
            17: r = 32'd5215;
            18: r = 32'd2608;
            19: r = 32'd1304;
            20: r = 32'd652;
            21: r = 32'd326;
            22: r = 32'd163;
            23: r = 32'd81;
            24: r = 32'd41;
            25: r = 32'd20;
            26: r = 32'd10;
            27: r = 32'd5;
            28: r = 32'd3;
            29: r = 32'd1;
            30: r = 32'd1;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

[rtl/psvp_cordic.sv]
`timescale 1ns / 1ps
// Pipelined CORDIC: one rotation per stage, quadrant fold in front, quadrant turn at the end.
// Carries the correlation matrices alongside. Depends on psvp_pkg.
module psvp_cordic import psvp_pkg::*; #(
    parameter int ITERATIONS = CORDIC_ITERATIONS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [31:0]          in_theta,
    input  corr4_t               in_mats,
    output logic                 out_valid,
    output logic signed [PW-1:0] out_cos,
    output logic signed [PW-1:0] out_sin,
    output corr4_t               out_mats
);

    localparam int STAGES = (ITERATIONS > CORDIC_TABLE_LEN) ? CORDIC_TABLE_LEN : ITERATIONS;

    typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_t;

    logic signed [CW-1:0] x_reg    [0:STAGES];
    logic signed [CW-1:0] y_reg    [0:STAGES];
    logic signed [CW-1:0] z_reg    [0:STAGES];
    quad_t                q_reg    [0:STAGES];
    corr4_t               mats_reg [0:STAGES];
    logic                 valid_reg[0:STAGES];

    logic [31:0] theta_bias;
    logic [31:0] resid;
    quad_t       quad;

    assign theta_bias = in_theta + QUARTER_HALF;
    assign quad       = quad_t'(theta_bias[31:30]);
    assign resid      = in_theta - {theta_bias[31:30], 30'd0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= CORDIC_GAIN;
            y_reg[0]    <= '0;
            z_reg[0]    <= CW'($signed(resid));
            q_reg[0]    <= quad;
            mats_reg[0] <= in_mats;
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_iter
        logic signed [CW-1:0] step;
        logic signed [CW-1:0] x_next, y_next, z_next;

        assign step = CW'(atan_turn(i));

        always_comb begin
            if (!z_reg[i][CW-1]) begin
                x_next = x_reg[i] - (y_reg[i] >>> i);
                y_next = y_reg[i] + (x_reg[i] >>> i);
                z_next = z_reg[i] - step;
            end else begin
                x_next = x_reg[i] + (y_reg[i] >>> i);
                y_next = y_reg[i] - (x_reg[i] >>> i);
                z_next = z_reg[i] + step;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i+1] <= 1'b0;
            end else if (en) begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[i+1]    <= x_next;
                y_reg[i+1]    <= y_next;
                z_reg[i+1]    <= z_next;
                q_reg[i+1]    <= q_reg[i];
                mats_reg[i+1] <= mats_reg[i];
            end
        end
    end

    logic signed [CW-1:0] cos_full, sin_full;
    logic signed [PW-1:0] cos_reg, sin_reg;
    corr4_t               omats_reg;
    logic                 ovalid_reg;

    always_comb begin
        case (q_reg[STAGES])
            QUAD_0: begin
                cos_full = x_reg[STAGES];
                sin_full = y_reg[STAGES];
            end
            QUAD_1: begin
                cos_full = -y_reg[STAGES];
                sin_full = x_reg[STAGES];
            end
            QUAD_2: begin
                cos_full = -x_reg[STAGES];
                sin_full = -y_reg[STAGES];
            end
            default: begin
                cos_full = y_reg[STAGES];
                sin_full = -x_reg[STAGES];
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovalid_reg <= 1'b0;
        end else if (en) begin
            ovalid_reg <= valid_reg[STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_reg   <= PW'(cos_full >>> 2);
            sin_reg   <= PW'(sin_full >>> 2);
            omats_reg <= mats_reg[STAGES];
        end
    end

    assign out_valid = ovalid_reg;
    assign out_cos   = cos_reg;
    assign out_sin   = sin_reg;
    assign out_mats  = omats_reg;

endmodule

[rtl/point_source_visibility_predictor.sv]
`timescale 1ns / 1ps
// Top level of the point-source visibility predictor: phase, Jones products, scaling.
// Depends on psvp_pkg and psvp_cordic.
//
// Usage: one word on s_data per baseline and channel (uvw in mm, frequency, two
// Jones matrices) gives one word on m_data with four Q8.23 complex correlations.
// Both channels are valid/ready. The user writes source l, m, n-1 and flux through
// cfg_we/cfg_index/cfg_wdata only while no word is in flight; this is unchecked.
// Throughput: one word per cycle, sustained while m_ready is high.
// Pipeline: four stages of phase arithmetic in front, the CORDIC (quadrant fold,
// one stage per iteration, quadrant turn) and four stages of complex multiply,
// flux scaling and saturation behind. When m_ready is low with a word waiting,
// the whole pipeline holds and s_ready drops; nothing is lost or repeated. Reset
// (aresetn low at a clock edge) empties the pipeline and loads l = m = n-1 = 0
// and flux = 1 Jy.
module point_source_visibility_predictor import psvp_pkg::*; #(
    parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  psvp_in_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output psvp_out_t   m_data
);

    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // configuration
    logic signed [31:0] src_l_reg, src_m_reg, src_n1_reg;
    logic [31:0]        flux_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_l_reg  <= '0;
            src_m_reg  <= '0;
            src_n1_reg <= '0;
            flux_reg   <= FLUX_RESET;
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                CFG_SRC_L:  src_l_reg  <= cfg_wdata;
                CFG_SRC_M:  src_m_reg  <= cfg_wdata;
                CFG_SRC_N1: src_n1_reg <= cfg_wdata;
                CFG_FLUX:   flux_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // stage 1: uvw products, frequency scale, Jones products
    logic signed [15:0] ar[4], ai[4], br[4], bi[4];
    assign ar[0] = s_data.jp_xx[31:16]; assign ai[0] = s_data.jp_xx[15:0];
    assign ar[1] = s_data.jp_xy[31:16]; assign ai[1] = s_data.jp_xy[15:0];
    assign ar[2] = s_data.jp_yx[31:16]; assign ai[2] = s_data.jp_yx[15:0];
    assign ar[3] = s_data.jp_yy[31:16]; assign ai[3] = s_data.jp_yy[15:0];
    assign br[0] = s_data.jq_xx[31:16]; assign bi[0] = s_data.jq_xx[15:0];
    assign br[1] = s_data.jq_xy[31:16]; assign bi[1] = s_data.jq_xy[15:0];
    assign br[2] = s_data.jq_yx[31:16]; assign bi[2] = s_data.jq_yx[15:0];
    assign br[3] = s_data.jq_yy[31:16]; assign bi[3] = s_data.jq_yy[15:0];

    corr4_t mats_next;

    always_comb begin
        logic signed [MW-1:0] mr, mi;
        logic [1:0] pi, qi;
        for (int c = 0; c < 4; c++) begin
            mr = '0;
            mi = '0;
            for (int kk = 0; kk < 2; kk++) begin
                pi = 2'((c / 2) * 2 + kk);
                qi = 2'((c % 2) * 2 + kk);
                mr = mr + ar[pi] * br[qi] + ai[pi] * bi[qi];
                mi = mi + ai[pi] * br[qi] - ar[pi] * bi[qi];
            end
            mats_next[c].re = mr;
            mats_next[c].im = mi;
        end
    end

    logic signed [63:0] pu_next, pv_next, pw_next;
    logic [63:0]        k_next;
    assign pu_next = $signed(s_data.u_m) * src_l_reg;
    assign pv_next = $signed(s_data.v_m) * src_m_reg;
    assign pw_next = $signed(s_data.w_m) * src_n1_reg;
    assign k_next  = 64'(s_data.freq_hz) * 64'(INV_C);

    logic               v1_reg;
    logic signed [63:0] pu_reg, pv_reg, pw_reg;
    logic [63:0]        k1_reg;
    corr4_t             mats1_reg;

    // stage 2: path length sum
    logic               v2_reg;
    logic signed [63:0] s_reg;
    logic [63:0]        k2_reg;
    corr4_t             mats2_reg;

    // stage 3: partial products of path times k
    logic signed [32:0] sh, sl, kh, kl;
    assign sh = {s_reg[63], s_reg[63:32]};
    assign sl = {1'b0, s_reg[31:0]};
    assign kh = {1'b0, k2_reg[63:32]};
    assign kl = {1'b0, k2_reg[31:0]};

    logic               v3_reg;
    logic signed [65:0] hh_reg, hl_reg, lh_reg, ll_reg;
    corr4_t             mats3_reg;

    // stage 4: phase in turns
    logic signed [99:0] phase_sum;
    assign phase_sum = (100'(hh_reg) <<< 64) + ((100'(hl_reg) + 100'(lh_reg)) <<< 32)
                     + 100'(ll_reg);

    logic        v4_reg;
    logic [31:0] t_reg;
    corr4_t      mats4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pu_reg    <= pu_next;
            pv_reg    <= pv_next;
            pw_reg    <= pw_next;
            k1_reg    <= k_next;
            mats1_reg <= mats_next;
            s_reg     <= (pu_reg >>> 2) + (pv_reg >>> 2) + (pw_reg >>> 2);
            k2_reg    <= k1_reg;
            mats2_reg <= mats1_reg;
            hh_reg    <= sh * kh;
            hl_reg    <= sh * kl;
            lh_reg    <= sl * kh;
            ll_reg    <= sl * kl;
            mats3_reg <= mats2_reg;
            t_reg     <= phase_sum[97:66];
            mats4_reg <= mats3_reg;
        end
    end

    // CORDIC
    logic                 cd_valid;
    logic signed [PW-1:0] cd_cos, cd_sin;
    corr4_t               cd_mats;

    psvp_cordic #(
        .ITERATIONS (CORDIC_ITERATIONS)
    ) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v4_reg),
        .in_theta  (32'd0 - t_reg),
        .in_mats   (mats4_reg),
        .out_valid (cd_valid),
        .out_cos   (cd_cos),
        .out_sin   (cd_sin),
        .out_mats  (cd_mats)
    );

    // rotate by phasor, scale by flux, saturate
    logic               vw1_reg, vw2_reg, vf1_reg, m_valid_reg;
    logic signed [65:0] wa_reg[4], wb_reg[4], wc_reg[4], wd_reg[4];
    logic signed [66:0] wre_reg[4], wim_reg[4];
    logic signed [67:0] rh_reg[4], ih_reg[4];
    logic signed [65:0] rl_reg[4], il_reg[4];
    psvp_out_t          out_next, m_data_reg;
    logic signed [32:0] flux_s;

    assign flux_s = {1'b0, flux_reg};

    function automatic logic [31:0] sat_q23(input logic signed [67:0] hi,
                                            input logic signed [65:0] lo);
        logic signed [99:0] p;
        logic [31:0]        r;
        p = (100'(hi) <<< 32) + 100'(lo);
        if (p[99:80] == {20{p[80]}}) begin
            r = p[80:49];
        end else if (p[99]) begin
            r = SAT_NEG;
        end else begin
            r = SAT_POS;
        end
        return r;
    endfunction

    for (genvar c = 0; c < 4; c++) begin : g_corr
        logic signed [34:0] re_h, im_h;
        logic signed [32:0] re_l, im_l;
        assign re_h = wre_reg[c][66:32];
        assign im_h = wim_reg[c][66:32];
        assign re_l = {1'b0, wre_reg[c][31:0]};
        assign im_l = {1'b0, wim_reg[c][31:0]};

        always_ff @(posedge aclk) begin
            if (en) begin
                wa_reg[c]  <= cd_mats[c].re * cd_cos;
                wb_reg[c]  <= cd_mats[c].im * cd_sin;
                wc_reg[c]  <= cd_mats[c].re * cd_sin;
                wd_reg[c]  <= cd_mats[c].im * cd_cos;
                wre_reg[c] <= 67'(wa_reg[c]) - 67'(wb_reg[c]);
                wim_reg[c] <= 67'(wc_reg[c]) + 67'(wd_reg[c]);
                rh_reg[c]  <= re_h * flux_s;
                ih_reg[c]  <= im_h * flux_s;
                rl_reg[c]  <= re_l * flux_s;
                il_reg[c]  <= im_l * flux_s;
            end
        end
    end

    always_comb begin
        out_next.vis_xx = {sat_q23(rh_reg[0], rl_reg[0]), sat_q23(ih_reg[0], il_reg[0])};
        out_next.vis_xy = {sat_q23(rh_reg[1], rl_reg[1]), sat_q23(ih_reg[1], il_reg[1])};
        out_next.vis_yx = {sat_q23(rh_reg[2], rl_reg[2]), sat_q23(ih_reg[2], il_reg[2])};
        out_next.vis_yy = {sat_q23(rh_reg[3], rl_reg[3]), sat_q23(ih_reg[3], il_reg[3])};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vw1_reg     <= 1'b0;
            vw2_reg     <= 1'b0;
            vf1_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vw1_reg     <= cd_valid;
            vw2_reg     <= vw1_reg;
            vf1_reg     <= vw2_reg;
            m_valid_reg <= vf1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid after reset");

    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> v1_reg)
        else $error("accepted word not in first stage");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(v4_reg) && $stable(vf1_reg) && $stable(cd_valid))
        else $error("pipeline moved during stall");

    a_cordic_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cd_valid && en |=> vw1_reg)
        else $error("rotated word dropped");

endmodule
